// ===== rtl/core/rdma_pkg.sv =====
// Shared types, codes and defaults for the region-decoded memory access block.
// Used by the top level, rdma_ctrl and rdma_dpath under rtl/core; depends on nothing else.
`default_nettype none

package rdma_pkg;

  localparam int BYTE_W = 8;

  localparam longint unsigned MAIN_BYTES_DEF  = 64'd65536;
  localparam longint unsigned VIDEO_BYTES_DEF = 64'd65536;

  // Access opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_MAIN  = 2'd0;
  localparam logic [1:0] STAT_VIDEO = 2'd1;
  localparam logic [1:0] STAT_HW    = 2'd2;
  localparam logic [1:0] STAT_NONE  = 2'd3;

  // Configuration register indexes (register i sits at byte address 8*i)
  localparam int         CFG_IDX_W     = 3;
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_RAM_BASE  = 3'd1;
  localparam logic [2:0] REG_VRAM_BASE = 3'd2;
  localparam logic [2:0] REG_HW_BASE   = 3'd3;
  localparam logic [2:0] REG_HW_SIZE   = 3'd4;

  localparam int HW_SIZE_W = 33;

  localparam logic [63:0]          RAM_BASE_RST  = 64'h0;
  localparam logic [63:0]          VRAM_BASE_RST = 64'h1_0000;
  localparam logic [63:0]          HW_BASE_RST   = 64'h2_0000;
  localparam logic [HW_SIZE_W-1:0] HW_SIZE_RST   = 33'h1_0000;

  typedef struct packed {
    logic                 enable;
    logic [63:0]          ram_base;
    logic [63:0]          vram_base;
    logic [63:0]          hw_base;
    logic [HW_SIZE_W-1:0] hw_size;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write zero at the sweep address, advance it
    logic load;    // capture the incoming word
    logic decode;  // resolve the window and the starting offset
    logic issue;   // access one byte
    logic finish;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/region_decoded_memory_access.sv =====
// Region-decoded little-endian memory access block.
//
// Input stream s_*: one access word (opcode in s_tuser, address, size and write
// data in s_tdata). Output stream m_*: one result word per access (read data in
// m_tdata, status in m_tuser). Configuration goes through an APB port with five
// 64-bit registers at byte addresses 0, 8, 16, 24, 32; write only while idle.
//
// After reset the block zeroes both stores, one byte address per cycle, over
// byte addresses 0 to max(MAIN_BYTES, VIDEO_BYTES)-1; s_tready stays low
// during the sweep. Each access then goes from accept to m_tvalid through the
// decode state; the issue state, which serves the bytes one at a time on the
// store's single port (none for hardware, unmapped or disabled hits, up to 8)
// and collects the last read byte in its closing step; and the done state,
// which loads the output register. A new access is taken only once the
// previous result has been loaded.
// The output register holds its word while m_tready is low; the next access
// may still be accepted and processed and waits only to be loaded.
// Depends on rdma_pkg, rdma_ctrl, rdma_dpath and rdma_ram.
`default_nettype none

module region_decoded_memory_access #(
  parameter longint unsigned MAIN_BYTES  = rdma_pkg::MAIN_BYTES_DEF,
  parameter longint unsigned VIDEO_BYTES = rdma_pkg::VIDEO_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,   // address[63:0], size_code[65:64], write_data[129:66]
  input  wire logic [0:0]   s_tuser,   // opcode[0]
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,   // read_data[63:0]
  output logic [1:0]        m_tuser,   // status[1:0]
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import rdma_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b0;
      cfg.ram_base  <= RAM_BASE_RST;
      cfg.vram_base <= VRAM_BASE_RST;
      cfg.hw_base   <= HW_BASE_RST;
      cfg.hw_size   <= HW_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENABLE:    cfg.enable    <= pwdata[0];
        REG_RAM_BASE:  cfg.ram_base  <= pwdata;
        REG_VRAM_BASE: cfg.vram_base <= pwdata;
        REG_HW_BASE:   cfg.hw_base   <= pwdata;
        REG_HW_SIZE:   cfg.hw_size   <= pwdata[HW_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:    prdata = {63'b0, cfg.enable};
      REG_RAM_BASE:  prdata = cfg.ram_base;
      REG_VRAM_BASE: prdata = cfg.vram_base;
      REG_HW_BASE:   prdata = cfg.hw_base;
      REG_HW_SIZE:   prdata = {{(64-HW_SIZE_W){1'b0}}, cfg.hw_size};
      default:       prdata = '0;
    endcase
  end

  rdma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdma_dpath #(
    .MAIN_BYTES  (MAIN_BYTES),
    .VIDEO_BYTES (VIDEO_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (s_tuser[0]),
    .in_address    (s_tdata[63:0]),
    .in_size_code  (s_tdata[65:64]),
    .in_write_data (s_tdata[129:66]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_read_data (m_tdata),
    .out_status    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rdma_ram.sv =====
// Generic single-port RAM with registered read, no reset on the array.
// Standalone; depends on nothing else.
`default_nettype none

module rdma_ram #(
  parameter int              WIDTH = 8,
  parameter longint unsigned DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rdma_ctrl.sv =====
// Sequencer for the memory access block: clearing sweep, accept, decode, byte issue, result load.
// Depends on rdma_pkg for the command and status structs.
`default_nettype none

module rdma_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rdma_pkg::stat_t stat,
  output rdma_pkg::cmd_t       cmd
);
  import rdma_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = stat.more;
        // last read byte lands in the accumulator as we leave
        if (!stat.more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rdma_dpath.sv =====
// Datapath: clearing sweep, window decode, byte-serial access to both stores, output register.
// Depends on rdma_pkg and rdma_ram.
`default_nettype none

module rdma_dpath #(
  parameter longint unsigned MAIN_BYTES  = rdma_pkg::MAIN_BYTES_DEF,
  parameter longint unsigned VIDEO_BYTES = rdma_pkg::VIDEO_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rdma_pkg::cfg_t  cfg,
  input  wire rdma_pkg::cmd_t  cmd,
  output rdma_pkg::stat_t      stat,
  input  wire logic            in_opcode,
  input  wire logic [63:0]     in_address,
  input  wire logic [1:0]      in_size_code,
  input  wire logic [63:0]     in_write_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [63:0]          out_read_data,
  output logic [1:0]           out_status
);
  import rdma_pkg::*;

  localparam longint unsigned MAX_BYTES =
    (MAIN_BYTES > VIDEO_BYTES) ? MAIN_BYTES : VIDEO_BYTES;
  localparam int MAIN_AW  = $clog2(MAIN_BYTES);
  localparam int VIDEO_AW = $clog2(VIDEO_BYTES);
  localparam int CLR_W    = $clog2(MAX_BYTES);
  localparam int POS_W    = $clog2(MAX_BYTES + 64'd1);

  localparam logic [POS_W-1:0] MAIN_LEN  = POS_W'(MAIN_BYTES);
  localparam logic [POS_W-1:0] VIDEO_LEN = POS_W'(VIDEO_BYTES);
  localparam logic [CLR_W:0]   MAIN_CLR  = (CLR_W+1)'(MAIN_BYTES);
  localparam logic [CLR_W:0]   VIDEO_CLR = (CLR_W+1)'(VIDEO_BYTES);
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(MAX_BYTES - 64'd1);

  // Captured access
  logic        op_r;
  logic [63:0] addr_r;
  logic [1:0]  size_r;
  logic [63:0] wdata_r;

  logic [1:0]       win_r;
  logic [POS_W-1:0] pos_r;
  logic [3:0]       cnt_r;
  logic [63:0]      acc_r;
  logic             cap_valid;
  logic [2:0]       cap_lane;
  logic             cap_video;
  logic [CLR_W-1:0] clr_addr;

  // Window decode: 65-bit difference, borrow means below base
  logic [64:0] d_main, d_video, d_hw;
  logic        hit_main, hit_video, hit_hw;
  logic [1:0]  win_dec;
  logic [POS_W-1:0] pos_dec;

  assign d_main  = {1'b0, addr_r} - {1'b0, cfg.ram_base};
  assign d_video = {1'b0, addr_r} - {1'b0, cfg.vram_base};
  assign d_hw    = {1'b0, addr_r} - {1'b0, cfg.hw_base};

  assign hit_main  = !d_main[64]  && (d_main[63:0]  < MAIN_BYTES);
  assign hit_video = !d_video[64] && (d_video[63:0] < VIDEO_BYTES);
  assign hit_hw    = !d_hw[64]    && (d_hw[63:0] < {31'b0, cfg.hw_size});

  always_comb begin
    win_dec = STAT_NONE;
    pos_dec = d_main[POS_W-1:0];
    priority if (!cfg.enable) begin
      win_dec = STAT_NONE;
    end else if (hit_main) begin
      win_dec = STAT_MAIN;
    end else if (hit_video) begin
      win_dec = STAT_VIDEO;
      pos_dec = d_video[POS_W-1:0];
    end else if (hit_hw) begin
      win_dec = STAT_HW;
    end else begin
      win_dec = STAT_NONE;
    end
  end

  // Byte issue
  logic [3:0] nbytes;
  logic       in_main, in_video;
  logic [2:0] lane;

  assign nbytes   = 4'd1 << size_r;
  assign lane     = cnt_r[2:0];
  assign in_main  = (win_r == STAT_MAIN)  && (pos_r < MAIN_LEN);
  assign in_video = (win_r == STAT_VIDEO) && (pos_r < VIDEO_LEN);

  assign stat.more       = (cnt_r < nbytes) && (in_main || in_video);
  assign stat.clear_done = (clr_addr == CLR_LAST);
  assign stat.out_free   = !out_valid || out_ready;

  // Store ports
  logic                main_we, video_we;
  logic [MAIN_AW-1:0]  main_addr;
  logic [VIDEO_AW-1:0] video_addr;
  logic [BYTE_W-1:0]   wbyte, main_wbyte, video_wbyte;
  logic [BYTE_W-1:0]   main_rd, video_rd;

  assign wbyte = wdata_r[lane*BYTE_W +: BYTE_W];

  always_comb begin
    if (cmd.clear) begin
      main_we     = ({1'b0, clr_addr} < MAIN_CLR);
      video_we    = ({1'b0, clr_addr} < VIDEO_CLR);
      main_addr   = clr_addr[MAIN_AW-1:0];
      video_addr  = clr_addr[VIDEO_AW-1:0];
      main_wbyte  = '0;
      video_wbyte = '0;
    end else begin
      main_we     = cmd.issue && in_main  && (op_r == OP_WRITE);
      video_we    = cmd.issue && in_video && (op_r == OP_WRITE);
      main_addr   = pos_r[MAIN_AW-1:0];
      video_addr  = pos_r[VIDEO_AW-1:0];
      main_wbyte  = wbyte;
      video_wbyte = wbyte;
    end
  end

  rdma_ram #(.WIDTH(BYTE_W), .DEPTH(MAIN_BYTES)) u_main (
    .clk   (clk),
    .we    (main_we),
    .addr  (main_addr),
    .wdata (main_wbyte),
    .rdata (main_rd)
  );

  rdma_ram #(.WIDTH(BYTE_W), .DEPTH(VIDEO_BYTES)) u_video (
    .clk   (clk),
    .we    (video_we),
    .addr  (video_addr),
    .wdata (video_wbyte),
    .rdata (video_rd)
  );

  // Payload and sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      addr_r  <= in_address;
      size_r  <= in_size_code;
      wdata_r <= in_write_data;
      acc_r   <= '0;
      cnt_r   <= '0;
    end
    if (cmd.decode) begin
      win_r <= win_dec;
      pos_r <= pos_dec;
    end
    if (cmd.issue) begin
      pos_r    <= pos_r + 1'b1;
      cnt_r    <= cnt_r + 1'b1;
      cap_lane <= lane;
      cap_video <= (win_r == STAT_VIDEO);
    end
    // read data shows in the cycle after the issue
    if (cap_valid) begin
      acc_r[cap_lane*BYTE_W +: BYTE_W] <= cap_video ? video_rd : main_rd;
    end
    if (cmd.finish) begin
      out_read_data <= acc_r;
      out_status    <= win_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      cap_valid <= cmd.issue && (op_r == OP_READ);
      if (cmd.clear && !stat.clear_done) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
